// ===== src/tss_pkg.sv =====
// Shared types and constants for the ternary search core.
// It has no dependencies. The core module imports it.
package tss_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int WORD_W = 32;
    localparam int POS_W = 10;

    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_THIRD,
        ST_MID,
        ST_PROBE_M1,
        ST_PROBE_M2,
        ST_PROBE_LOW,
        ST_PROBE_HIGH
    } state_t;

endpackage

// ===== src/ternary_search_sorted_array_core.sv =====
// Ternary search core: element memory, search sequencer and shared compare unit.
// It depends on tss_pkg for the state type, function codes and widths.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------
//  command  | start, busy        | func, value, first
//  result   | done (one cycle)   | found, position
//
// An append word is written straight into memory, and busy stays low.
// A search leaves idle, then each round steps through ST_THIRD, ST_MID and the probes, with
// about seven rounds over 1024 elements; the single read port of the element
// memory serves the four probes of each round, one per cycle.
// A hit ends the search at the probe that matches.
// Reset empties the array; memory contents stay undefined, with no clearing pass.
// The result is shown for one cycle on done, and the receiver cannot stall it.
module ternary_search_sorted_array_core
    import tss_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     func,
    input  logic signed [WORD_W-1:0] value,
    input  logic                     first,
    output logic                     done,
    output logic                     found,
    output logic [POS_W-1:0]         position
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int IW = CW + 1;
    localparam int S = AW + 1;
    localparam int PW = AW + S;
    localparam logic [S-1:0] RECIP = S'(((2 ** S) + 2) / 3);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ELEMENTS);

    logic signed [WORD_W-1:0] mem [MAX_ELEMENTS];

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic signed [IW-1:0]     low_reg, low_next;
    logic signed [IW-1:0]     high_reg, high_next;
    logic signed [IW-1:0]     m1_reg, m1_next;
    logic signed [IW-1:0]     m2_reg, m2_next;
    logic signed [WORD_W-1:0] key_reg, key_next;
    logic                     lt1_reg, lt1_next;
    logic                     gt2_reg, gt2_next;
    logic [PW-1:0]            product_reg, product_next;
    logic                     done_reg, done_next;
    logic                     found_reg, found_next;
    logic [POS_W-1:0]         position_reg, position_next;
    logic signed [WORD_W-1:0] rd_data_reg;

    logic                     accept;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;
    logic signed [IW-1:0]     diff;
    logic signed [IW-1:0]     third_s;
    logic signed [IW-1:0]     m1_calc;
    logic signed [IW-1:0]     m2_calc;
    logic                     key_eq;
    logic                     key_lt;
    logic                     key_gt;
    logic signed [IW-1:0]     narrow_low;
    logic signed [IW-1:0]     narrow_high;
    logic                     range_empty;

    assign accept = start && !busy;
    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign found = found_reg;
    assign position = position_reg;

    assign diff = high_reg - low_reg;
    assign third_s = signed'(IW'(product_reg[PW-1:S]));
    assign m1_calc = low_reg + third_s;
    assign m2_calc = high_reg - third_s;

    assign key_eq = (rd_data_reg == key_reg);
    assign key_lt = (key_reg < rd_data_reg);
    assign key_gt = (key_reg > rd_data_reg);

    always_comb
    begin
        narrow_low = m1_reg + IW'(1);
        narrow_high = m2_reg - IW'(1);
        if (lt1_reg)
        begin
            narrow_low = low_reg;
            narrow_high = m1_reg - IW'(1);
        end
        else if (gt2_reg)
        begin
            narrow_low = m2_reg + IW'(1);
            narrow_high = high_reg;
        end
    end

    assign range_empty = (narrow_low > narrow_high);

    assign wr_en = accept && (func == FUNC_APPEND) && (first || (count_reg < MAX_COUNT));
    assign wr_addr = first ? '0 : count_reg[AW-1:0];

    always_comb
    begin
        case (state_reg)
            ST_MID:        rd_addr = m1_calc[AW-1:0];
            ST_PROBE_M1:   rd_addr = m2_reg[AW-1:0];
            ST_PROBE_M2:   rd_addr = low_reg[AW-1:0];
            ST_PROBE_LOW:  rd_addr = high_reg[AW-1:0];
            default:       rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (func == FUNC_SEARCH) && (count_reg != '0))
                begin
                    state_next = ST_THIRD;
                end
            end
            ST_THIRD:      state_next = ST_MID;
            ST_MID:        state_next = ST_PROBE_M1;
            ST_PROBE_M1:   state_next = key_eq ? ST_IDLE : ST_PROBE_M2;
            ST_PROBE_M2:   state_next = key_eq ? ST_IDLE : ST_PROBE_LOW;
            ST_PROBE_LOW:  state_next = key_eq ? ST_IDLE : ST_PROBE_HIGH;
            ST_PROBE_HIGH: state_next = (key_eq || range_empty) ? ST_IDLE : ST_THIRD;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        low_next = low_reg;
        high_next = high_reg;
        m1_next = m1_reg;
        m2_next = m2_reg;
        key_next = key_reg;
        lt1_next = lt1_reg;
        gt2_next = gt2_reg;
        product_next = product_reg;
        done_next = 1'b0;
        found_next = 1'b0;
        position_next = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (func == FUNC_APPEND))
                begin
                    if (first)
                    begin
                        count_next = CW'(1);
                    end
                    else if (count_reg < MAX_COUNT)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                else if (accept)
                begin
                    key_next = value;
                    low_next = '0;
                    high_next = signed'(IW'(count_reg)) - IW'(1);
                    if (count_reg == '0)
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            ST_THIRD:
            begin
                product_next = PW'(diff[AW-1:0]) * PW'(RECIP);
            end
            ST_MID:
            begin
                m1_next = m1_calc;
                m2_next = m2_calc;
            end
            ST_PROBE_M1:
            begin
                lt1_next = key_lt;
                if (key_eq)
                begin
                    done_next = 1'b1;
                    found_next = 1'b1;
                    position_next = POS_W'($unsigned(m1_reg));
                end
            end
            ST_PROBE_M2:
            begin
                gt2_next = key_gt;
                if (key_eq)
                begin
                    done_next = 1'b1;
                    found_next = 1'b1;
                    position_next = POS_W'($unsigned(m2_reg));
                end
            end
            ST_PROBE_LOW:
            begin
                if (key_eq)
                begin
                    done_next = 1'b1;
                    found_next = 1'b1;
                    position_next = POS_W'($unsigned(low_reg));
                end
            end
            ST_PROBE_HIGH:
            begin
                if (key_eq)
                begin
                    done_next = 1'b1;
                    found_next = 1'b1;
                    position_next = POS_W'($unsigned(high_reg));
                end
                else
                begin
                    low_next = narrow_low;
                    high_next = narrow_high;
                    if (range_empty)
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg <= low_next;
        high_reg <= high_next;
        m1_reg <= m1_next;
        m2_reg <= m2_next;
        key_reg <= key_next;
        lt1_reg <= lt1_next;
        gt2_reg <= gt2_next;
        product_reg <= product_next;
        found_reg <= found_next;
        position_reg <= position_next;
    end

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("Result strobe while a search is still running.");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (position == '0))
        else $error("Nonzero position on a miss.");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("Element count beyond capacity.");

    a_probe_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE_M1) |-> ($past(state_reg) == ST_MID))
        else $error("First probe without split point update.");
`endif

endmodule

// ===== test/search_scoreboard_pkg.sv =====
// Scoreboard for the ternary search core: keeps its own copy of the loaded
// array, works out each search answer and checks the answers that come back.
// It depends on tss_pkg for widths, the function codes and the array depth.
package search_scoreboard_pkg;

    import tss_pkg::*;

    class search_scoreboard;

        logic signed [WORD_W-1:0] store [0:MAX_ELEMENTS_DEF-1];
        int                       count;
        bit                       exp_found [$];
        logic [POS_W-1:0]         exp_position [$];
        int                       errors;

        function new();
            count = 0;
            errors = 0;
        endfunction

        function int ternary_find(logic signed [WORD_W-1:0] key);
            int lo;
            int hi;
            int third;
            int m1;
            int m2;
            lo = 0;
            hi = count - 1;
            while (lo <= hi)
            begin
                third = (hi - lo) / 3;
                m1 = lo + third;
                m2 = hi - third;
                if (store[m1] == key)
                    return m1;
                if (store[m2] == key)
                    return m2;
                if (store[lo] == key)
                    return lo;
                if (store[hi] == key)
                    return hi;
                if (key < store[m1])
                    hi = m1 - 1;
                else if (key > store[m2])
                    lo = m2 + 1;
                else
                begin
                    lo = m1 + 1;
                    hi = m2 - 1;
                end
            end
            return -1;
        endfunction

        function void note_word(logic f, logic signed [WORD_W-1:0] v, logic fst);
            int hit;
            if (f == FUNC_APPEND)
            begin
                if (fst)
                    count = 0;
                if (count < MAX_ELEMENTS_DEF)
                begin
                    store[count] = v;
                    count++;
                end
            end
            else
            begin
                hit = ternary_find(v);
                exp_found.push_back(hit >= 0);
                exp_position.push_back(hit >= 0 ? hit[POS_W-1:0] : '0);
            end
        endfunction

        function void check_result(logic f, logic [POS_W-1:0] p);
            bit               want_found;
            logic [POS_W-1:0] want_position;
            if (exp_found.size() == 0)
            begin
                $display("%0t: unexpected result found=%b position=%0d", $time, f, p);
                errors++;
                return;
            end
            want_found = exp_found.pop_front();
            want_position = exp_position.pop_front();
            if (f !== want_found)
            begin
                $display("%0t: found mismatch, expected %b actual %b",
                         $time, want_found, f);
                errors++;
            end
            if (p !== want_position)
            begin
                $display("%0t: position mismatch, expected %0d actual %0d",
                         $time, want_position, p);
                errors++;
            end
        endfunction

        function int pending();
            return exp_found.size();
        endfunction

    endclass

endpackage

// ===== test/testbench.sv =====
// Self-checking testbench for ternary_search_sorted_array_core: loads arrays,
// fires searches at them and checks every answer against the scoreboard.
// It depends on tss_pkg, search_scoreboard_pkg and the core itself.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import tss_pkg::*;
    import search_scoreboard_pkg::*;

    localparam int RANDOM_WORDS = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 60;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     func = FUNC_APPEND;
    logic signed [WORD_W-1:0] value = '0;
    logic                     first = 1'b0;
    logic                     busy;
    logic                     done;
    logic                     found;
    logic [POS_W-1:0]         position;

    search_scoreboard         sb = new();
    logic signed [WORD_W-1:0] loaded [$];
    int                       idle_pct = 0;
    int                       words_sent = 0;
    int                       quiet_cycles = 0;

    ternary_search_sorted_array_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .func     (func),
        .value    (value),
        .first    (first),
        .done     (done),
        .found    (found),
        .position (position)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(found, position);
    end

    always @(posedge clk)
    begin
        if ((start && !busy && rst_n) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_word(input logic f, input logic signed [WORD_W-1:0] v,
                             input logic fst);
        start <= 1'b1;
        func <= f;
        value <= v;
        first <= fst;
        do
            @(posedge clk);
        while (busy);
        sb.note_word(f, v, fst);
        words_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [WORD_W-1:0] draw_value(input int mode);
        case (mode)
            0: return $urandom;
            1: return int'($urandom_range(40)) - 20;
            default:
                if ($urandom_range(1))
                    return 32'h7FFF_FFFF - $urandom_range(3);
                else
                    return 32'h8000_0000 + $urandom_range(3);
        endcase
    endfunction

    task automatic load_array(input int n, input int mode, input bit sorted);
        logic signed [WORD_W-1:0] vals [$];
        logic signed [WORD_W-1:0] v;
        int                       j;
        for (int i = 0; i < n; i++)
        begin
            v = draw_value(mode);
            j = 0;
            if (sorted)
                while (j < vals.size() && vals[j] <= v)
                    j++;
            else
                j = vals.size();
            vals.insert(j, v);
        end
        for (int i = 0; i < n; i++)
            send_word(FUNC_APPEND, vals[i], i == 0);
        loaded = vals;
    endtask

    function automatic logic signed [WORD_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (loaded.size() == 0 || sel >= 90)
            return draw_value(2);
        if (sel < 60)
            return loaded[$urandom_range(loaded.size() - 1)];
        if (sel < 80)
            return $urandom;
        return loaded[$urandom_range(loaded.size() - 1)] + ($urandom_range(1) ? 1 : -1);
    endfunction

    initial
    begin
        int rand_base;
        int phase;
        int prev_phase;
        int n;
        int mode;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(FUNC_SEARCH, 0, 1'b0);
        send_word(FUNC_APPEND, 32'h8000_0000, 1'b1);
        send_word(FUNC_APPEND, -5, 1'b0);
        send_word(FUNC_APPEND, 0, 1'b0);
        send_word(FUNC_APPEND, 0, 1'b0);
        send_word(FUNC_APPEND, 7, 1'b0);
        send_word(FUNC_APPEND, 32'h7FFF_FFFF, 1'b0);
        send_word(FUNC_SEARCH, 32'h8000_0000, 1'b0);
        send_word(FUNC_SEARCH, 32'h7FFF_FFFF, 1'b1);
        send_word(FUNC_SEARCH, 0, 1'b0);
        send_word(FUNC_SEARCH, 7, 1'b0);
        send_word(FUNC_SEARCH, -5, 1'b1);
        send_word(FUNC_SEARCH, 1, 1'b0);
        send_word(FUNC_SEARCH, -6, 1'b0);
        send_word(FUNC_APPEND, 42, 1'b1);
        send_word(FUNC_SEARCH, 42, 1'b0);
        send_word(FUNC_SEARCH, 41, 1'b0);
        send_word(FUNC_APPEND, 9, 1'b1);
        send_word(FUNC_APPEND, 1, 1'b0);
        send_word(FUNC_APPEND, 5, 1'b0);
        send_word(FUNC_SEARCH, 1, 1'b0);
        send_word(FUNC_SEARCH, 5, 1'b0);
        send_word(FUNC_SEARCH, 9, 1'b0);

        // Fill the array completely; further appends must be dropped.
        load_array(MAX_ELEMENTS_DEF, 0, 1'b1);
        send_word(FUNC_APPEND, $urandom, 1'b0);
        send_word(FUNC_APPEND, 32'h7FFF_FFFF, 1'b0);
        send_word(FUNC_SEARCH, loaded[0], 1'b0);
        send_word(FUNC_SEARCH, loaded[MAX_ELEMENTS_DEF - 1], 1'b0);
        send_word(FUNC_SEARCH, loaded[MAX_ELEMENTS_DEF / 2], 1'b0);
        send_word(FUNC_SEARCH, 32'h7FFF_FFFF, 1'b0);
        send_word(FUNC_SEARCH, $urandom, 1'b0);
        drain();

        rand_base = words_sent;
        prev_phase = 0;
        while (words_sent - rand_base < RANDOM_WORDS)
        begin
            phase = (words_sent - rand_base) * 3 / RANDOM_WORDS;
            if (phase != prev_phase)
                drain();
            prev_phase = phase;
            idle_pct = (phase == 0) ? 12 : (phase == 1) ? 67 : 0;

            n = ($urandom_range(9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
            mode = $urandom_range(2);
            load_array(n, mode, $urandom_range(9) != 0);
            if ($urandom_range(9) == 0)
            begin
                loaded.push_back(draw_value(mode));
                send_word(FUNC_APPEND, loaded[loaded.size() - 1], 1'b0);
            end
            repeat ($urandom_range(1, 8))
                send_word(FUNC_SEARCH, pick_key(), 1'($urandom_range(1)));
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
